/* hdl/bmb_pkg.sv */
// ----------------------------------------------------------------------------
// Bounded multiset bag package
// Command codes, fixed field widths and the control bundle shared by the
// slot cells and the bag controller.
// ----------------------------------------------------------------------------
package bmb_pkg;

    localparam int CMD_W   = 2;
    localparam int VALUE_W = 32;
    localparam int COUNT_W = 5;

    localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd3;

    typedef struct packed {
        logic shift;
        logic wrap;
        logic append;
    } cell_ctrl_t;

endpackage

/* hdl/bmb_if.sv */
// ----------------------------------------------------------------------------
// Bounded multiset bag channels
// Request channel (command and entry value) and response channel (status,
// count and frequency), each with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface bmb_req_if;
    import bmb_pkg::*;

    logic               valid;
    logic               ready;
    logic [CMD_W-1:0]   command;
    logic [VALUE_W-1:0] entry_value;

    modport source (output valid, output command, output entry_value, input ready);
    modport sink   (input valid, input command, input entry_value, output ready);
endinterface

interface bmb_rsp_if;
    import bmb_pkg::*;

    logic               valid;
    logic               ready;
    logic               success;
    logic [COUNT_W-1:0] entry_count;
    logic [COUNT_W-1:0] match_frequency;
    logic               is_present;

    modport source (output valid, output success, output entry_count,
                    output match_frequency, output is_present, input ready);
    modport sink   (input valid, input success, input entry_count,
                    input match_frequency, input is_present, output ready);
endinterface

/* hdl/bmb_cell.sv */
// ----------------------------------------------------------------------------
// Bounded multiset bag slot cell
// One storage slot of the chain. During a scan it takes its upper neighbor's
// value, or the head value when it is the last occupied slot and the head
// wraps around; on an append it loads the new entry if it is the first free
// slot.
// ----------------------------------------------------------------------------
module bmb_cell #(
    parameter int ENTRY_WIDTH = 32,
    parameter int CNT_W       = 5,
    parameter int INDEX       = 0
) (
    input  logic                    clk,
    input  bmb_pkg::cell_ctrl_t     ctrl,
    input  logic [CNT_W-1:0]        count,
    input  logic [ENTRY_WIDTH-1:0]  head_value,
    input  logic [ENTRY_WIDTH-1:0]  next_value,
    input  logic [ENTRY_WIDTH-1:0]  new_value,
    output logic [ENTRY_WIDTH-1:0]  slot_value
);
    import bmb_pkg::*;

    logic [ENTRY_WIDTH-1:0] slot_reg;
    logic [ENTRY_WIDTH-1:0] slot_next;
    logic                   is_free_slot;
    logic                   is_tail;

    always_comb
    begin
        is_free_slot = (count == CNT_W'(INDEX));
        is_tail      = (count == CNT_W'(INDEX + 1));
        slot_next    = slot_reg;
        if (ctrl.append && is_free_slot)
        begin
            slot_next = new_value;
        end
        else if (ctrl.shift)
        begin
            if (ctrl.wrap && is_tail)
            begin
                slot_next = head_value;
            end
            else
            begin
                slot_next = next_value;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg <= slot_next;
    end

    assign slot_value = slot_reg;

endmodule

/* hdl/bounded_multiset_bag.sv */
// ----------------------------------------------------------------------------
// Bounded multiset bag
// Fixed-capacity unordered multiset held in a chain of slot cells. A scan
// rotates the occupied slots past the head once, counting matches and
// dropping the first match on a remove; an add appends at the first free slot.
// ----------------------------------------------------------------------------
// Timing: a request is taken only in idle; it then passes through the scan state, where
//   the cell chain rotates one slot per cycle past the compare at the head, and the finish
//   state, which holds while the previous response is not yet taken and then loads the
//   response. A clear or an empty bag skips the scan; no new request is taken until then.
// Reset: the entry count and all handshake state clear; slot contents do not.
module bounded_multiset_bag #(
    parameter int CAPACITY    = 16,
    parameter int ENTRY_WIDTH = 32
) (
    input  logic       clk,
    input  logic       rst_n,
    bmb_req_if.sink    req,
    bmb_rsp_if.source  rsp
);
    import bmb_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);

    typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_FINISH} state_t;

    state_t                 state_reg;
    logic [CMD_W-1:0]       cmd_reg;
    logic [ENTRY_WIDTH-1:0] value_reg;
    logic [CNT_W-1:0]       count_reg;
    logic [CNT_W-1:0]       remain_reg;
    logic [CNT_W-1:0]       match_reg;
    logic                   removed_reg;
    logic                   rsp_valid_reg;
    logic                   rsp_success_reg;
    logic [COUNT_W-1:0]     rsp_count_reg;
    logic [COUNT_W-1:0]     rsp_freq_reg;
    logic                   rsp_present_reg;

    logic [ENTRY_WIDTH-1:0] slot_q [CAPACITY];
    logic [ENTRY_WIDTH-1:0] req_value;
    logic [ENTRY_WIDTH-1:0] head_value;
    cell_ctrl_t             cell_ctrl;
    logic                   hit;
    logic                   drop;
    logic                   out_free;
    logic                   has_room;
    logic [CNT_W-1:0]       final_count;
    logic [CNT_W-1:0]       final_freq;
    logic                   final_ok;

    always_comb
    begin
        req_value  = ENTRY_WIDTH'(req.entry_value);
        head_value = slot_q[0];
        hit        = (head_value == value_reg);
        drop       = (state_reg == ST_SCAN) && (cmd_reg == CMD_REMOVE) && hit && !removed_reg;
        out_free   = !rsp_valid_reg || rsp.ready;
        has_room   = (count_reg < CNT_W'(CAPACITY));

        cell_ctrl.shift  = (state_reg == ST_SCAN);
        cell_ctrl.wrap   = !drop;
        cell_ctrl.append = (state_reg == ST_FINISH) && out_free &&
                           (cmd_reg == CMD_ADD) && has_room;

        final_count = count_reg;
        final_freq  = match_reg;
        final_ok    = 1'b1;
        case (cmd_reg)
            CMD_ADD:
            begin
                final_ok = has_room;
                if (has_room)
                begin
                    final_count = count_reg + CNT_W'(1);
                    final_freq  = match_reg + CNT_W'(1);
                end
            end
            CMD_REMOVE:
            begin
                final_ok = removed_reg;
            end
            CMD_CLEAR:
            begin
                final_count = '0;
                final_freq  = '0;
            end
            CMD_QUERY:
            begin
                final_ok = 1'b1;
            end
            default:
            begin
                final_ok = 1'b1;
            end
        endcase
    end

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            logic [ENTRY_WIDTH-1:0] next_value;
            if (gi == CAPACITY - 1)
            begin : g_last
                assign next_value = head_value;
            end
            else
            begin : g_mid
                assign next_value = slot_q[gi + 1];
            end

            bmb_cell #(
                .ENTRY_WIDTH (ENTRY_WIDTH),
                .CNT_W       (CNT_W),
                .INDEX       (gi)
            ) u_cell (
                .clk        (clk),
                .ctrl       (cell_ctrl),
                .count      (count_reg),
                .head_value (head_value),
                .next_value (next_value),
                .new_value  (value_reg),
                .slot_value (slot_q[gi])
            );
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            cmd_reg         <= CMD_QUERY;
            value_reg       <= '0;
            count_reg       <= '0;
            remain_reg      <= '0;
            match_reg       <= '0;
            removed_reg     <= 1'b0;
            rsp_valid_reg   <= 1'b0;
            rsp_success_reg <= 1'b0;
            rsp_count_reg   <= '0;
            rsp_freq_reg    <= '0;
            rsp_present_reg <= 1'b0;
        end
        else
        begin
            if (rsp_valid_reg && rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (req.valid)
                    begin
                        cmd_reg     <= req.command;
                        value_reg   <= req_value;
                        remain_reg  <= count_reg;
                        match_reg   <= '0;
                        removed_reg <= 1'b0;
                        if ((req.command == CMD_CLEAR) || (count_reg == '0))
                        begin
                            state_reg <= ST_FINISH;
                        end
                        else
                        begin
                            state_reg <= ST_SCAN;
                        end
                    end
                end
                ST_SCAN:
                begin
                    if (drop)
                    begin
                        count_reg   <= count_reg - CNT_W'(1);
                        removed_reg <= 1'b1;
                    end
                    else if (hit)
                    begin
                        match_reg <= match_reg + CNT_W'(1);
                    end
                    remain_reg <= remain_reg - CNT_W'(1);
                    if (remain_reg == CNT_W'(1))
                    begin
                        state_reg <= ST_FINISH;
                    end
                end
                ST_FINISH:
                begin
                    if (out_free)
                    begin
                        count_reg       <= final_count;
                        rsp_valid_reg   <= 1'b1;
                        rsp_success_reg <= final_ok;
                        rsp_count_reg   <= COUNT_W'(final_count);
                        rsp_freq_reg    <= COUNT_W'(final_freq);
                        rsp_present_reg <= (final_freq != '0);
                        state_reg       <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign req.ready           = (state_reg == ST_IDLE);
    assign rsp.valid           = rsp_valid_reg;
    assign rsp.success         = rsp_success_reg;
    assign rsp.entry_count     = rsp_count_reg;
    assign rsp.match_frequency = rsp_freq_reg;
    assign rsp.is_present      = rsp_present_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("Entry count exceeds capacity.");

    a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> !req.ready)
        else $error("Request taken while a previous one is still in progress.");

    a_remove_only: assert property (@(posedge clk) disable iff (!rst_n)
        removed_reg |-> (cmd_reg == CMD_REMOVE))
        else $error("Entry dropped by a command other than remove.");

    a_match_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINISH) |-> (match_reg <= count_reg))
        else $error("Match count exceeds the number of stored entries.");

endmodule
